// ===== hw/rtl/paged_framebuffer_dirty_flush_unit_assert.svh =====
// Assertion macros for the paged frame buffer flush unit.
`ifndef PAGED_FRAMEBUFFER_DIRTY_FLUSH_UNIT_ASSERT_SVH
`define PAGED_FRAMEBUFFER_DIRTY_FLUSH_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define PFDF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("pfdf implication check failed");
`define PFDF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("pfdf next-cycle check failed");
`else
`define PFDF_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PFDF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/pfdf_pkg.sv =====
// Shared types and constants of the paged frame buffer flush unit.
package pfdf_pkg;

	typedef struct packed {
		logic       req_type;
		logic [7:0] pixel_x;
		logic [7:0] pixel_y;
		logic       clear_pixel;
	} req_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_command;
		logic       byte_valid;
		logic       sweep_done;
	} rsp_word_t;

	// Result of the dirty-page search.
	typedef struct packed {
		logic       found;
		logic [3:0] page;
		logic [7:0] first_col;
		logic [7:0] last_col;
	} scan_res_t;

	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_PULL  = 1'b1;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_CMD1 = 2'd1;
	localparam logic [1:0] PH_CMD2 = 2'd2;
	localparam logic [1:0] PH_DATA = 2'd3;

	localparam logic [7:0] CLEAN_MARK  = 8'hFF;
	localparam logic [7:0] CMD_COL_HI  = 8'h10;
	localparam logic [7:0] CMD_PAGE    = 8'hB0;
	localparam logic [3:0] NIBBLE_MASK = 4'hF;
	localparam logic [6:0] COL_OFFSET_RESET = 7'd2;

endpackage

// ===== hw/rtl/pfdf_page_scan.sv =====
// Dirty test and priority search for the next dirty page of the sweep.
module pfdf_page_scan #(
	parameter int COLUMNS = 128,
	parameter int PAGES   = 8
) (
	input  logic [PAGES-1:0][7:0] dirty_first,
	input  logic [PAGES-1:0][7:0] dirty_last,
	input  logic [3:0]            sweep_page,
	output pfdf_pkg::scan_res_t   res
);
	import pfdf_pkg::*;

	logic [PAGES-1:0] cand;

	always_comb begin
		for (int p = 0; p < PAGES; p++) begin
			cand[p] = (dirty_first[p] < 8'(COLUMNS)) && (dirty_last[p] < 8'(COLUMNS)) &&
				(dirty_first[p] <= dirty_last[p]) && (4'(p) >= sweep_page);
		end
	end

	// Lowest candidate wins: walk downward so the last hit stands.
	always_comb begin
		res = '0;
		for (int p = PAGES - 1; p >= 0; p--) begin
			if (cand[p]) begin
				res.found     = 1'b1;
				res.page      = 4'(p);
				res.first_col = dirty_first[p];
				res.last_col  = dirty_last[p];
			end
		end
	end

endmodule

// ===== hw/rtl/paged_framebuffer_dirty_flush_unit.sv =====
// Top level: page-organized frame store with dirty ranges and flush byte stream.
//
//  channel | signals                         | carries
//  --------+---------------------------------+-----------------------------------
//  request | req_valid, req_stall, req_word  | pixel write or pull of next byte
//  result  | rsp_valid, rsp_stall, rsp_word  | one word per pull, none per pixel
//  config  | cfg_wr_en, cfg_wr_data          | column offset, no read-back
//
// Each request word passes through stage 1: the accept edge issues the frame store read,
// then stage 1 finishes the read-modify-write or loads the free result register.
// The single frame store port lets only one request word be in stage 1 at a time.
// After reset a clearing pass zeroes all PAGES << clog2(COLUMNS) frame store entries
// (1024 by default); requests are stalled during it, config writes are taken.
// A pull whose result register is still full and stalled waits in stage 1;
// pixel writes finish regardless of the result side.
`include "paged_framebuffer_dirty_flush_unit_assert.svh"
module paged_framebuffer_dirty_flush_unit #(
	parameter int COLUMNS = 128,
	parameter int PAGES   = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  pfdf_pkg::req_word_t req_word,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output pfdf_pkg::rsp_word_t rsp_word,
	input  logic                cfg_wr_en,
	input  logic [6:0]          cfg_wr_data
);
	import pfdf_pkg::*;

	localparam int CW        = $clog2(COLUMNS);
	localparam int PW        = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int AW        = PW + CW;
	localparam int MEM_DEPTH = PAGES << CW;

	// Frame store: address is {page, column}.
	logic [7:0]    mem [MEM_DEPTH];
	logic [7:0]    mem_rdata_q;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;

	// Clearing pass after reset.
	logic          clr_busy_q;
	logic [AW-1:0] clr_addr_q;

	logic [6:0] col_off_q;

	// Flush sequencer.
	logic [1:0] phase_q;
	logic [3:0] sweep_page_q;
	logic [7:0] send_col_q;
	logic [7:0] send_end_q;
	logic [PAGES-1:0][7:0] dirty_first_q;
	logic [PAGES-1:0][7:0] dirty_last_q;

	// Stage 1.
	logic      busy_s1;
	req_word_t item_s1;

	logic      rsp_valid_q;
	rsp_word_t rsp_word_q;

	scan_res_t scan;

	logic       accept;
	logic       s1_pixel;
	logic       s1_pull_done;
	logic       pix_hit;
	logic [4:0] pix_page;
	logic [7:0] pix_mask;
	logic [7:0] disp_col;
	logic [7:0] first_disp;
	rsp_word_t  pull_res;

	pfdf_page_scan #(
		.COLUMNS(COLUMNS),
		.PAGES  (PAGES)
	) u_scan (
		.dirty_first(dirty_first_q),
		.dirty_last (dirty_last_q),
		.sweep_page (sweep_page_q),
		.res        (scan)
	);

	// Stall while clearing and while stage 1 holds an item (single memory port).
	assign req_stall = clr_busy_q || busy_s1;
	assign accept    = req_valid && !req_stall;

	assign s1_pixel     = busy_s1 && (item_s1.req_type == REQ_PIXEL);
	assign s1_pull_done = busy_s1 && (item_s1.req_type == REQ_PULL) &&
		(!rsp_valid_q || !rsp_stall);

	assign pix_page = item_s1.pixel_y[7:3];
	assign pix_hit  = s1_pixel && (item_s1.pixel_x < 8'(COLUMNS)) &&
		(item_s1.pixel_y < 8'(8 * PAGES));
	assign pix_mask = 8'd1 << item_s1.pixel_y[2:0];

	// Read at accept: pixel byte, or the data byte of the current flush column.
	assign mem_re = accept;
	always_comb begin
		if (req_word.req_type == REQ_PIXEL) begin
			mem_raddr = {req_word.pixel_y[PW+2:3], req_word.pixel_x[CW-1:0]};
		end else begin
			mem_raddr = {sweep_page_q[PW-1:0], send_col_q[CW-1:0]};
		end
	end

	// Write port: clearing pass first, then the pixel write-back.
	always_comb begin
		if (clr_busy_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = '0;
		end else begin
			mem_we    = pix_hit;
			mem_waddr = {item_s1.pixel_y[PW+2:3], item_s1.pixel_x[CW-1:0]};
			mem_wdata = item_s1.clear_pixel ? (mem_rdata_q & ~pix_mask)
				: (mem_rdata_q | pix_mask);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rdata_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == AW'(MEM_DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_off_q <= COL_OFFSET_RESET;
		end else if (cfg_wr_en) begin
			col_off_q <= cfg_wr_data;
		end
	end

	assign disp_col   = send_col_q + {1'b0, col_off_q};
	assign first_disp = scan.first_col + {1'b0, col_off_q};

	// Result word of a pull, from the state as it stands in stage 1.
	always_comb begin
		pull_res = '0;
		unique case (phase_q)
			PH_CMD1: begin
				pull_res.out_byte   = CMD_COL_HI | {4'd0, disp_col[7:4]};
				pull_res.is_command = 1'b1;
				pull_res.byte_valid = 1'b1;
			end
			PH_CMD2: begin
				pull_res.out_byte   = CMD_PAGE | {4'd0, sweep_page_q};
				pull_res.is_command = 1'b1;
				pull_res.byte_valid = 1'b1;
			end
			PH_DATA: begin
				if ((sweep_page_q < 4'(PAGES)) && (send_col_q < 8'(COLUMNS))) begin
					pull_res.out_byte = mem_rdata_q;
				end
				pull_res.byte_valid = 1'b1;
			end
			PH_IDLE: begin
				if (scan.found) begin
					pull_res.out_byte   = {4'd0, first_disp[3:0] & NIBBLE_MASK};
					pull_res.is_command = 1'b1;
					pull_res.byte_valid = 1'b1;
				end else begin
					pull_res.sweep_done = 1'b1;
				end
			end
		endcase
	end

	// Stage 1 occupancy: a pixel always retires, a pull waits for the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
		end else if (accept) begin
			busy_s1 <= 1'b1;
		end else if (s1_pixel || s1_pull_done) begin
			busy_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= req_word;
		end
	end

	// Sequencer state advance on a finished pull.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			sweep_page_q <= '0;
			send_col_q   <= '0;
			send_end_q   <= '0;
		end else if (s1_pull_done) begin
			unique case (phase_q)
				PH_CMD1: phase_q <= PH_CMD2;
				PH_CMD2: phase_q <= PH_DATA;
				PH_DATA: begin
					if (send_col_q >= send_end_q) begin
						phase_q      <= PH_IDLE;
						sweep_page_q <= sweep_page_q + 4'd1;
					end else begin
						send_col_q <= send_col_q + 8'd1;
					end
				end
				PH_IDLE: begin
					if (scan.found) begin
						phase_q      <= PH_CMD1;
						sweep_page_q <= scan.page;
						send_col_q   <= scan.first_col;
						send_end_q   <= scan.last_col;
					end else begin
						sweep_page_q <= '0;
					end
				end
			endcase
		end
	end

	// Dirty ranges: widen on a pixel write, drop when a page is latched.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < PAGES; p++) begin
				dirty_first_q[p] <= CLEAN_MARK;
				dirty_last_q[p]  <= CLEAN_MARK;
			end
		end else begin
			for (int p = 0; p < PAGES; p++) begin
				if (pix_hit && (pix_page == 5'(p))) begin
					if (dirty_first_q[p] > item_s1.pixel_x) begin
						dirty_first_q[p] <= item_s1.pixel_x;
					end
					if ((dirty_last_q[p] < item_s1.pixel_x) ||
						(dirty_last_q[p] >= 8'(COLUMNS))) begin
						dirty_last_q[p] <= item_s1.pixel_x;
					end
				end else if (s1_pull_done && (phase_q == PH_IDLE) && scan.found &&
					(scan.page == 4'(p))) begin
					dirty_first_q[p] <= CLEAN_MARK;
					dirty_last_q[p]  <= CLEAN_MARK;
				end
			end
		end
	end

	// Result register: load on a finished pull, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_pull_done) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_pull_done) begin
			rsp_word_q <= pull_res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_word_q;

	`PFDF_ASSERT_IMPL(a_rsp_from_s1, clk, arst_n, $rose(rsp_valid_q), $past(busy_s1))
	`PFDF_ASSERT_IMPL(a_done_idle, clk, arst_n, rsp_valid_q && rsp_word_q.sweep_done, !rsp_word_q.byte_valid && (phase_q == PH_IDLE))
	`PFDF_ASSERT_IMPL(a_page_in_range, clk, arst_n, phase_q != PH_IDLE, sweep_page_q < 4'(PAGES))
	`PFDF_ASSERT_NEXT(a_pixel_retires, clk, arst_n, s1_pixel, !busy_s1)

endmodule

// ===== tb/sv/tb_paged_framebuffer_dirty_flush_unit.sv =====
// Testbench for the paged frame buffer flush unit: pixel writes and flush pulls against a predictor.
`timescale 1ns / 100ps

module tb_paged_framebuffer_dirty_flush_unit;
	import pfdf_pkg::*;

	localparam int COLUMNS      = 128;
	localparam int PAGES        = 8;
	// Watchdog limit; the slowest correct run (clearing pass, bursts, long hold) stays well under it.
	localparam int LIMIT_CYCLES = 400000;
	localparam int LONG_HOLD    = 300;
	localparam int PHASE_ITEMS  = 500;
	// Pixel words give no result word, so let the pipe empty before a config write.
	localparam int SETTLE       = 8;
	localparam int MAX_REPORTS  = 10;

	// Frame store mirror with dirty ranges and the flush stream sequencer.
	class flush_stream_scoreboard;
		logic [7:0] page_bytes [PAGES][COLUMNS];
		logic [7:0] first_col [PAGES];
		logic [7:0] last_col [PAGES];
		logic [3:0] sweep_page;
		logic [1:0] send_phase;
		logic [7:0] send_column;
		logic [7:0] send_end;
		logic [6:0] column_offset;
		rsp_word_t  expected_bytes[$];
		int         errors;
		int         results_seen;

		function new();
			foreach (page_bytes[p, c]) page_bytes[p][c] = 8'h00;
			foreach (first_col[p]) begin
				first_col[p] = CLEAN_MARK;
				last_col[p]  = CLEAN_MARK;
			end
			sweep_page    = '0;
			send_phase    = PH_IDLE;
			send_column   = '0;
			send_end      = '0;
			column_offset = COL_OFFSET_RESET;
			errors        = 0;
			results_seen  = 0;
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= MAX_REPORTS) $display("%s", msg);
		endfunction

		// Physical column of the current send column, 8-bit wrap.
		function logic [7:0] shown_column();
			return send_column + {1'b0, column_offset};
		endfunction

		function void note_request(req_word_t w);
			rsp_word_t  r;
			int         px;
			int         py;
			int         pg;
			logic [7:0] mask;
			logic [7:0] col;
			bit         found;
			if (w.req_type == REQ_PIXEL) begin
				px = w.pixel_x;
				py = w.pixel_y;
				if (px >= COLUMNS || py >= 8 * PAGES) return;
				pg   = py >> 3;
				mask = 8'h01 << py[2:0];
				if (w.clear_pixel) page_bytes[pg][px] = page_bytes[pg][px] & ~mask;
				else page_bytes[pg][px] = page_bytes[pg][px] | mask;
				if (first_col[pg] > px) first_col[pg] = px[7:0];
				if (last_col[pg] < px || last_col[pg] >= COLUMNS) last_col[pg] = px[7:0];
				return;
			end
			r = '0;
			found = 0;
			case (send_phase)
				PH_CMD1: begin
					col          = shown_column();
					r.out_byte   = CMD_COL_HI | {4'h0, col[7:4]};
					r.is_command = 1'b1;
					r.byte_valid = 1'b1;
					send_phase   = PH_CMD2;
				end
				PH_CMD2: begin
					r.out_byte   = CMD_PAGE | {4'h0, sweep_page};
					r.is_command = 1'b1;
					r.byte_valid = 1'b1;
					send_phase   = PH_DATA;
				end
				PH_DATA: begin
					if (sweep_page < PAGES && send_column < COLUMNS)
						r.out_byte = page_bytes[sweep_page][send_column];
					r.byte_valid = 1'b1;
					if (send_column >= send_end) begin
						send_phase = PH_IDLE;
						sweep_page = sweep_page + 4'd1;
					end else begin
						send_column = send_column + 8'd1;
					end
				end
				default: begin
					for (int p = sweep_page; p < PAGES && !found; p++) begin
						if (first_col[p] < COLUMNS && last_col[p] < COLUMNS &&
								first_col[p] <= last_col[p]) begin
							found        = 1;
							sweep_page   = p[3:0];
							send_column  = first_col[p];
							send_end     = last_col[p];
							first_col[p] = CLEAN_MARK;
							last_col[p]  = CLEAN_MARK;
							col          = shown_column();
							r.out_byte   = {4'h0, col[3:0] & NIBBLE_MASK};
							r.is_command = 1'b1;
							r.byte_valid = 1'b1;
							send_phase   = PH_CMD1;
						end
					end
					if (!found) begin
						sweep_page  = '0;
						send_phase  = PH_IDLE;
						r.sweep_done = 1'b1;
					end
				end
			endcase
			expected_bytes.push_back(r);
		endfunction

		function void check_result(rsp_word_t got);
			rsp_word_t want;
			results_seen++;
			if (expected_bytes.size() == 0) begin
				flag($sformatf("unexpected result word: byte %02h cmd %0b valid %0b done %0b",
					got.out_byte, got.is_command, got.byte_valid, got.sweep_done));
				return;
			end
			want = expected_bytes.pop_front();
			if (got.out_byte !== want.out_byte || got.is_command !== want.is_command ||
					got.byte_valid !== want.byte_valid || got.sweep_done !== want.sweep_done)
				flag($sformatf({"result word mismatch: expected byte %02h cmd %0b valid %0b ",
					"done %0b, got byte %02h cmd %0b valid %0b done %0b"},
					want.out_byte, want.is_command, want.byte_valid, want.sweep_done,
					got.out_byte, got.is_command, got.byte_valid, got.sweep_done));
		endfunction
	endclass

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        req_valid   = 1'b0;
	logic        req_stall;
	req_word_t   req_word    = '0;
	logic        rsp_valid;
	logic        rsp_stall   = 1'b0;
	rsp_word_t   rsp_word;
	logic        cfg_wr_en   = 1'b0;
	logic [6:0]  cfg_wr_data = '0;

	flush_stream_scoreboard board = new();

	// Final stretch of the run: no idling on either side.
	bit calm        = 0;
	int idle_pct    = 20;
	int cluster_page = 0;
	int cluster_x    = 0;

	paged_framebuffer_dirty_flush_unit #(
		.COLUMNS(COLUMNS),
		.PAGES  (PAGES)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req_word   (req_word),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp_word   (rsp_word),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always #5 clk = ~clk;

	// Hard stop: anything that hangs ends the run here.
	initial begin : watchdog
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("DONE: errors detected");
		$finish;
	end

	// Result side: check each accepted word at the rising edge, then pick the
	// stall for the next cycle at the falling edge. One long hold-off lets the
	// block fill up and push back on the request side.
	initial begin : result_side
		int burst;
		int hold;
		bit long_hold_done;
		burst          = 0;
		hold           = 0;
		long_hold_done = 0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && !rsp_stall) board.check_result(rsp_word);
			@(negedge clk);
			if (!long_hold_done && board.results_seen >= 80) begin
				long_hold_done = 1;
				hold           = LONG_HOLD;
			end
			if (hold > 0) begin
				hold--;
				rsp_stall = 1'b1;
			end else if (burst > 0) begin
				burst--;
				rsp_stall = 1'b1;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				burst     = $urandom_range(0, 10);
				rsp_stall = 1'b1;
			end else begin
				rsp_stall = 1'b0;
			end
		end
	end

	function automatic req_word_t pixel_word(int x, int y, bit clr);
		req_word_t w;
		w             = '0;
		w.req_type    = REQ_PIXEL;
		w.pixel_x     = x[7:0];
		w.pixel_y     = y[7:0];
		w.clear_pixel = clr;
		return w;
	endfunction

	function automatic req_word_t pull_word();
		req_word_t w;
		w          = '0;
		w.req_type = REQ_PULL;
		return w;
	endfunction

	// Mostly clustered pixel writes and pulls, so flushes stay short and
	// complete; the rest is scattered writes and out-of-range noise.
	function automatic req_word_t random_request();
		req_word_t w;
		int        roll;
		int        x;
		w    = '0;
		roll = $urandom_range(0, 99);
		if (roll < 45) begin
			w.req_type    = REQ_PULL;
			w.pixel_x     = 8'($urandom);
			w.pixel_y     = 8'($urandom);
			w.clear_pixel = 1'($urandom);
		end else begin
			w.req_type    = REQ_PIXEL;
			w.clear_pixel = ($urandom_range(0, 2) == 0);
			if (roll < 80) begin
				if ($urandom_range(0, 9) == 0) begin
					cluster_page = $urandom_range(0, PAGES - 1);
					cluster_x    = $urandom_range(0, COLUMNS - 1);
				end
				x = cluster_x + $urandom_range(0, 7);
				if (x >= COLUMNS) x = COLUMNS - 1;
				w.pixel_x = x[7:0];
				w.pixel_y = 8'(cluster_page * 8 + $urandom_range(0, 7));
			end else if (roll < 90) begin
				w.pixel_x = 8'($urandom_range(0, COLUMNS - 1));
				w.pixel_y = 8'($urandom_range(0, 8 * PAGES - 1));
			end else begin
				w.pixel_x = 8'($urandom_range(0, 255));
				w.pixel_y = 8'($urandom_range(0, 255));
			end
		end
		return w;
	endfunction

	// Offer one request word at the falling edge; hold it until accepted.
	task automatic issue_word(input req_word_t w);
		if (!calm && $urandom_range(0, 99) < idle_pct) begin
			@(negedge clk);
			req_valid = 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		@(negedge clk);
		req_valid = 1'b1;
		req_word  = w;
		do @(posedge clk); while (req_stall);
		board.note_request(w);
	endtask

	// Drop valid, wait for every pending result word, then let the pipe empty.
	task automatic drain_flush();
		@(negedge clk);
		req_valid = 1'b0;
		while (board.expected_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_offset(input logic [6:0] value);
		@(negedge clk);
		cfg_wr_en   = 1'b1;
		cfg_wr_data = value;
		@(posedge clk);
		board.column_offset = value;
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	task automatic random_phase(input int count);
		int pick;
		for (int i = 0; i < count; i++) begin
			// Vary the sender's idling in stretches, some of them with none.
			if (i % 64 == 0) begin
				pick     = $urandom_range(0, 2);
				idle_pct = (pick == 0) ? 0 : (pick == 1) ? 15 : 40;
			end
			issue_word(random_request());
		end
	endtask

	initial begin : stimulus
		req_word_t script[$];
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Offset 14 makes the last column carry into the high nibble.
		write_offset(7'd14);

		// Directed: empty pass, edge pixels, ignored coordinates, clear,
		// a write that lands in the page being flushed, and a second pass.
		script.push_back(pull_word());
		script.push_back(pixel_word(0, 0, 0));
		script.push_back(pixel_word(COLUMNS - 1, 8 * PAGES - 1, 0));
		script.push_back(pixel_word(COLUMNS, 5, 0));
		script.push_back(pixel_word(3, 8 * PAGES, 0));
		script.push_back(pixel_word(255, 255, 1));
		script.push_back(pixel_word(2, 1, 0));
		script.push_back(pixel_word(0, 0, 1));
		repeat (3) script.push_back(pull_word());
		script.push_back(pixel_word(1, 7, 0));
		repeat (13) script.push_back(pull_word());
		foreach (script[i]) issue_word(script[i]);
		drain_flush();

		write_offset(7'd0);
		random_phase(PHASE_ITEMS);
		drain_flush();

		write_offset(7'd127);
		random_phase(PHASE_ITEMS);
		drain_flush();

		write_offset(7'($urandom_range(1, 126)));
		random_phase(PHASE_ITEMS);
		drain_flush();

		// Last stretch runs at full rate on both sides.
		write_offset(COL_OFFSET_RESET);
		calm = 1;
		random_phase(PHASE_ITEMS);
		drain_flush();

		if (board.expected_bytes.size() != 0)
			board.flag($sformatf("%0d result words never arrived", board.expected_bytes.size()));
		if (board.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/pfdf_pkg.sv
hw/rtl/pfdf_page_scan.sv
hw/rtl/paged_framebuffer_dirty_flush_unit.sv
tb/sv/tb_paged_framebuffer_dirty_flush_unit.sv
